// ----- rtl/cbc_pkg.sv -----
// shared types, codes and constants of the cartridge bank controller
package cbc_pkg;

	localparam int ADDR_W        = 16;
	localparam int DATA_W        = 8;
	localparam int ROM_ADDR_W    = 23;
	localparam int ROM_BANK_W    = 9;
	localparam int RAM_BANK_W    = 8;
	localparam int RAM_LIN_W     = 17;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 5;

	localparam int RAM_BYTES_DEF     = 32768;
	localparam int ROM_ADDR_BITS_DEF = 23;

	localparam logic [DATA_W-1:0]     OPEN_BUS     = 8'hFF;
	localparam logic [3:0]            RAM_EN_KEY   = 4'hA;
	localparam logic [RAM_BANK_W-1:0] RTC_BANK_LO  = 8'h08;
	localparam logic [RAM_BANK_W-1:0] RTC_BANK_SEC = 8'h08;
	localparam logic [RAM_BANK_W-1:0] RTC_BANK_MIN = 8'h09;
	localparam logic [RAM_BANK_W-1:0] RTC_BANK_HRS = 8'h0A;
	localparam logic [RAM_BANK_W-1:0] RTC_BANK_DL  = 8'h0B;
	localparam logic [RAM_BANK_W-1:0] RTC_BANK_DH  = 8'h0C;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		MAP_NONE = 3'd0,
		MAP_MBC1 = 3'd1,
		MAP_MBC2 = 3'd2,
		MAP_MBC3 = 3'd3,
		MAP_MBC5 = 3'd4
	} mapper_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAPPER   = 2'd0,
		CFG_ROM_LOG2 = 2'd1,
		CFG_RAM_LOG2 = 2'd2,
		CFG_CLOCK    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SRC_FIXED      = 2'd0,
		SRC_RAM_BYTE   = 2'd1,
		SRC_RAM_NIBBLE = 2'd2
	} rd_src_t;

	typedef enum logic [2:0] {
		RTC_SEC = 3'd0,
		RTC_MIN = 3'd1,
		RTC_HRS = 3'd2,
		RTC_DL  = 3'd3,
		RTC_DH  = 3'd4
	} rtc_sel_t;

	typedef struct packed {
		logic [2:0] mapper_type;
		logic [3:0] rom_banks_log2;
		logic [4:0] ram_size_log2;
		logic       has_clock;
	} cfg_t;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hrs;
		logic [7:0] dl;
		logic [7:0] dh;
	} rtc_t;

	typedef struct packed {
		logic              tick;
		logic              latch;
		logic              wr;
		rtc_sel_t          sel;
		logic [DATA_W-1:0] data;
	} rtc_cmd_t;

	typedef struct packed {
		logic en;
		logic we;
	} ram_ctl_t;

	typedef struct packed {
		logic                  fetch;
		logic [ROM_ADDR_W-1:0] rom_address;
		logic [DATA_W-1:0]     data;
		rd_src_t               src;
		logic                  dirty;
	} res_t;

endpackage

// ----- rtl/cbc_req_if.sv -----
// request channel: bus read, bus write or clock tick
interface cbc_req_if import cbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, output req_type, output address, output write_data,
		input ready);
	modport sink (input valid, input req_type, input address, input write_data,
		output ready);
endinterface

// ----- rtl/cbc_rsp_if.sv -----
// result channel: rom fetch address, read data and dirty flag
interface cbc_rsp_if import cbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  rom_fetch;
	logic [ROM_ADDR_W-1:0] rom_address;
	logic [DATA_W-1:0]     read_data;
	logic                  ram_dirty;

	modport source (output valid, output rom_fetch, output rom_address, output read_data,
		output ram_dirty, input ready);
	modport sink (input valid, input rom_fetch, input rom_address, input read_data,
		input ram_dirty, output ready);
endinterface

// ----- rtl/cbc_cfg_if.sv -----
// configuration write channel
interface cbc_cfg_if import cbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/cbc_ram.sv -----
// generic single-port ram with registered read
module cbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/cbc_rtc.sv -----
// real-time clock: live and latched counters, tick carry chain
module cbc_rtc import cbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rtc_cmd_t cmd,
	output rtc_t     live,
	output rtc_t     latched
);

	rtc_t live_q, latched_q, live_d, tick_v;
	logic [8:0] day;

	// counters only carry on an exact match, out-of-range values just wrap
	always_comb begin
		tick_v     = live_q;
		day        = {live_q.dh[0], live_q.dl} + 9'd1;
		tick_v.sec = live_q.sec + 6'd1;
		if (tick_v.sec == 6'd60) begin
			tick_v.sec = '0;
			tick_v.min = live_q.min + 6'd1;
			if (tick_v.min == 6'd60) begin
				tick_v.min = '0;
				tick_v.hrs = live_q.hrs + 5'd1;
				if (tick_v.hrs == 5'd24) begin
					tick_v.hrs   = '0;
					tick_v.dl    = day[7:0];
					tick_v.dh[0] = day[8];
					if ({live_q.dh[0], live_q.dl} == 9'h1FF) begin
						tick_v.dh[7] = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		live_d = live_q;
		if (cmd.tick) begin
			live_d = tick_v;
		end else if (cmd.wr) begin
			case (cmd.sel)
				RTC_SEC: live_d.sec = cmd.data[5:0];
				RTC_MIN: live_d.min = cmd.data[5:0];
				RTC_HRS: live_d.hrs = cmd.data[4:0];
				RTC_DL:  live_d.dl  = cmd.data;
				RTC_DH:  live_d.dh  = cmd.data & 8'hC1;
				default: live_d = live_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			latched_q <= '0;
		end else begin
			live_q <= live_d;
			if (cmd.latch) begin
				latched_q <= live_q;
			end
		end
	end

	assign live    = live_q;
	assign latched = latched_q;

endmodule

// ----- rtl/cbc_ctrl.sv -----
// mapper registers and decode of one staged bus beat
module cbc_ctrl import cbc_pkg::*; #(
	parameter int RAM_BYTES     = RAM_BYTES_DEF,
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
	localparam int AW = $clog2(RAM_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [1:0]        req_type,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_data,
	input  cfg_t              cfg,
	input  rtc_t              rtc_live,
	input  rtc_t              rtc_latched,
	output ram_ctl_t          ram_ctl,
	output logic [AW-1:0]     ram_addr,
	output logic [DATA_W-1:0] ram_wdata,
	output rtc_cmd_t          rtc_cmd,
	output res_t              res
);

	localparam logic [ROM_ADDR_W-1:0] ROM_MASK =
		ROM_ADDR_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

	mapper_t                 kind;
	logic                    ram_en_q, ram_en_d;
	logic [ROM_BANK_W-1:0]   rom_bank_q, rom_bank_d;
	logic [RAM_BANK_W-1:0]   ram_bank_q, ram_bank_d;
	logic                    mode_q, mode_d;
	logic [DATA_W-1:0]       latch_prev_q, latch_prev_d;
	logic                    dirty_q, dirty_set;
	logic                    is_read, is_write, is_tick;
	logic                    in_rom0, in_romx, in_win, in_regs;
	logic                    ram_on, rtc_map, no_ram, ram_rd, ram_wr;
	logic [3:0]              ram_bank_sel;
	logic [RAM_LIN_W-1:0]    ram_lin;
	logic [AW-1:0]           size_mask, byte_idx, nib_idx;
	logic [ROM_BANK_W-1:0]   rom_bank_sel, rom_bank_mask;
	logic [ROM_ADDR_W-1:0]   rom_phys;
	logic                    key_ok;

	always_comb begin
		kind = MAP_NONE;
		case (cfg.mapper_type)
			MAP_MBC1: kind = MAP_MBC1;
			MAP_MBC2: kind = MAP_MBC2;
			MAP_MBC3: kind = MAP_MBC3;
			MAP_MBC5: kind = MAP_MBC5;
			default:  kind = MAP_NONE;
		endcase
	end

	assign is_read  = (req_type == REQ_READ);
	assign is_write = (req_type == REQ_WRITE);
	assign is_tick  = (req_type == REQ_TICK);
	assign in_rom0  = (address[15:14] == 2'b00);
	assign in_romx  = (address[15:14] == 2'b01);
	assign in_regs  = !address[15];
	assign in_win   = (address[15:13] == 3'b101);
	assign ram_on   = (kind == MAP_NONE) || ram_en_q;
	assign rtc_map  = (kind == MAP_MBC3) && (ram_bank_q >= RTC_BANK_LO);
	assign no_ram   = (cfg.ram_size_log2 == '0);
	assign key_ok   = (write_data[3:0] == RAM_EN_KEY);

	// ram offset: bank and window offset, wrapped to the usable size
	always_comb begin
		case (kind)
			MAP_MBC1: ram_bank_sel = mode_q ? {2'b00, ram_bank_q[1:0]} : 4'd0;
			MAP_MBC3: ram_bank_sel = {1'b0, ram_bank_q[2:0]};
			MAP_MBC5: ram_bank_sel = ram_bank_q[3:0];
			default:  ram_bank_sel = 4'd0;
		endcase
		ram_lin = {ram_bank_sel, address[12:0]};
		for (int i = 0; i < AW; i++) begin
			size_mask[i] = (cfg.ram_size_log2 > 5'(i));
		end
		byte_idx = ram_lin[AW-1:0] & size_mask;
		nib_idx  = AW'(address[8:0]);
	end

	// rom bank for the fixed and switchable windows, masked to the rom size
	always_comb begin
		rom_bank_sel = 9'd1;
		if (in_rom0) begin
			rom_bank_sel = ((kind == MAP_MBC1) && mode_q) ?
				{2'b00, ram_bank_q[1:0], 5'd0} : 9'd0;
		end else begin
			case (kind)
				MAP_MBC1: rom_bank_sel = {2'b00, ram_bank_q[1:0], rom_bank_q[4:0]};
				MAP_MBC2: rom_bank_sel = {5'd0, rom_bank_q[3:0]};
				MAP_MBC3: rom_bank_sel = {2'b00, rom_bank_q[6:0]};
				MAP_MBC5: rom_bank_sel = rom_bank_q;
				default:  rom_bank_sel = 9'd1;
			endcase
		end
		for (int j = 0; j < ROM_BANK_W; j++) begin
			rom_bank_mask[j] = (cfg.rom_banks_log2 > 4'(j));
		end
		rom_phys = {rom_bank_sel & rom_bank_mask, address[13:0]} & ROM_MASK;
	end

	always_comb begin
		ram_en_d     = ram_en_q;
		rom_bank_d   = rom_bank_q;
		ram_bank_d   = ram_bank_q;
		mode_d       = mode_q;
		latch_prev_d = latch_prev_q;
		dirty_set    = 1'b0;
		ram_rd       = 1'b0;
		ram_wr       = 1'b0;
		rtc_cmd      = '{tick: 1'b0, latch: 1'b0, wr: 1'b0, sel: RTC_SEC, data: write_data};
		res.fetch       = is_read && (in_rom0 || in_romx);
		res.rom_address = res.fetch ? rom_phys : '0;
		res.data        = OPEN_BUS;
		res.src         = SRC_FIXED;

		if (is_read && in_win && ram_on) begin
			if (kind == MAP_MBC2) begin
				res.src = SRC_RAM_NIBBLE;
				ram_rd  = 1'b1;
			end else if (rtc_map) begin
				case (ram_bank_q)
					RTC_BANK_SEC: res.data = {2'b00, rtc_latched.sec};
					RTC_BANK_MIN: res.data = {2'b00, rtc_latched.min};
					RTC_BANK_HRS: res.data = {3'b000, rtc_latched.hrs};
					RTC_BANK_DL:  res.data = rtc_latched.dl;
					RTC_BANK_DH:  res.data = rtc_latched.dh;
					default:      res.data = OPEN_BUS;
				endcase
			end else if (!no_ram) begin
				res.src = SRC_RAM_BYTE;
				ram_rd  = 1'b1;
			end
		end

		if (is_write && in_regs) begin
			case (kind)
				MAP_MBC1: begin
					case (address[14:13])
						2'b00: ram_en_d = key_ok;
						2'b01: rom_bank_d = (write_data[4:0] == '0) ? 9'd1 :
							{4'd0, write_data[4:0]};
						2'b10: ram_bank_d = {6'd0, write_data[1:0]};
						default: mode_d = write_data[0];
					endcase
				end
				MAP_MBC2: begin
					if (!address[14]) begin
						if (address[8]) begin
							rom_bank_d = (write_data[3:0] == '0) ? 9'd1 :
								{5'd0, write_data[3:0]};
						end else begin
							ram_en_d = key_ok;
						end
					end
				end
				MAP_MBC3: begin
					case (address[14:13])
						2'b00: ram_en_d = key_ok;
						2'b01: rom_bank_d = (write_data[6:0] == '0) ? 9'd1 :
							{2'b00, write_data[6:0]};
						2'b10: ram_bank_d = write_data;
						default: begin
							// a zero then a one copies the live clock to the latch
							rtc_cmd.latch = (latch_prev_q == 8'h00) && (write_data == 8'h01);
							latch_prev_d  = write_data;
						end
					endcase
				end
				MAP_MBC5: begin
					case (address[14:12])
						3'b000, 3'b001: ram_en_d = key_ok;
						3'b010: rom_bank_d = {rom_bank_q[8], write_data};
						3'b011: rom_bank_d = {write_data[0], rom_bank_q[7:0]};
						3'b100, 3'b101: ram_bank_d = {4'd0, write_data[3:0]};
						default: ram_bank_d = ram_bank_q;
					endcase
				end
				default: ram_en_d = ram_en_q;
			endcase
		end

		if (is_write && in_win && ram_on) begin
			if (kind == MAP_MBC2) begin
				ram_wr    = 1'b1;
				dirty_set = 1'b1;
			end else if (rtc_map) begin
				dirty_set = 1'b1;
				case (ram_bank_q)
					RTC_BANK_SEC: begin rtc_cmd.wr = 1'b1; rtc_cmd.sel = RTC_SEC; end
					RTC_BANK_MIN: begin rtc_cmd.wr = 1'b1; rtc_cmd.sel = RTC_MIN; end
					RTC_BANK_HRS: begin rtc_cmd.wr = 1'b1; rtc_cmd.sel = RTC_HRS; end
					RTC_BANK_DL:  begin rtc_cmd.wr = 1'b1; rtc_cmd.sel = RTC_DL; end
					RTC_BANK_DH:  begin rtc_cmd.wr = 1'b1; rtc_cmd.sel = RTC_DH; end
					default:      rtc_cmd.wr = 1'b0;
				endcase
			end else if (!no_ram) begin
				ram_wr    = 1'b1;
				dirty_set = 1'b1;
			end
		end

		// halted or absent clock ignores the tick
		if (is_tick && cfg.has_clock && !rtc_live.dh[6]) begin
			rtc_cmd.tick = 1'b1;
			dirty_set    = 1'b1;
		end

		rtc_cmd.tick  = rtc_cmd.tick && fire;
		rtc_cmd.latch = rtc_cmd.latch && fire;
		rtc_cmd.wr    = rtc_cmd.wr && fire;
		res.dirty     = dirty_q || dirty_set;
	end

	assign ram_ctl.en = fire && (ram_rd || ram_wr);
	assign ram_ctl.we = fire && ram_wr;
	assign ram_addr   = (kind == MAP_MBC2) ? nib_idx : byte_idx;
	assign ram_wdata  = (kind == MAP_MBC2) ? {4'd0, write_data[3:0]} : write_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q     <= 1'b0;
			rom_bank_q   <= 9'd1;
			ram_bank_q   <= '0;
			mode_q       <= 1'b0;
			latch_prev_q <= 8'hFF;
			dirty_q      <= 1'b0;
		end else if (fire) begin
			ram_en_q     <= ram_en_d;
			rom_bank_q   <= rom_bank_d;
			ram_bank_q   <= ram_bank_d;
			mode_q       <= mode_d;
			latch_prev_q <= latch_prev_d;
			dirty_q      <= res.dirty;
		end
	end

endmodule

// ----- rtl/cartridge_bank_controller_rtc_unit.sv -----
// an accepted request beat passes through s1 (decode) and then s2 (result) to its result beat
// throughput: one request beat per cycle while rsp.ready holds, limited by the single cartridge ram port
// a stalled result holds s2 and s1; a new beat still enters while s2 drains the same cycle
// reset: mapper and clock registers clear at once, then a clearing pass writes 0xFF to
// every cartridge ram byte, with req.ready low throughout; config writes always taken
module cartridge_bank_controller_rtc_unit import cbc_pkg::*; #(
	parameter int RAM_BYTES     = RAM_BYTES_DEF,
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cbc_req_if.sink    req,
	cbc_rsp_if.source  rsp,
	cbc_cfg_if.sink    cfg
);

	// ram address width; RAM_BYTES is a power of two
	localparam int AW = $clog2(RAM_BYTES);

	// configuration registers
	cfg_t cfg_q;

	// input stage
	logic              valid_s1;
	logic [1:0]        req_type_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [DATA_W-1:0] write_data_s1;

	// result stage
	logic                  valid_s2;
	logic                  fetch_s2;
	logic [ROM_ADDR_W-1:0] rom_address_s2;
	logic [DATA_W-1:0]     data_s2;
	rd_src_t               src_s2;
	logic                  dirty_s2;

	// clearing pass
	logic [AW-1:0] clr_idx_q;
	logic          clr_done_q;

	// handshake
	logic s2_free, s1_fire;

	// decode outputs and ram port
	ram_ctl_t          dec_ram_ctl;
	logic [AW-1:0]     dec_ram_addr;
	logic [DATA_W-1:0] dec_ram_wdata;
	rtc_cmd_t          rtc_cmd;
	res_t              dec_res;
	rtc_t              rtc_live, rtc_latched;
	logic              ram_en, ram_we;
	logic [AW-1:0]     ram_addr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	// s1 moves on only when the result stage is empty or draining
	assign s2_free   = !valid_s2 || rsp.ready;
	assign s1_fire   = valid_s1 && s2_free;
	assign req.ready = clr_done_q && (!valid_s1 || s2_free);
	assign cfg.ready = 1'b1;

	// configuration beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mapper_type: 3'd0, rom_banks_log2: 4'd1,
				ram_size_log2: 5'd0, has_clock: 1'b0};
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MAPPER:   cfg_q.mapper_type    <= cfg.data[2:0];
				CFG_ROM_LOG2: cfg_q.rom_banks_log2 <= cfg.data[3:0];
				CFG_RAM_LOG2: cfg_q.ram_size_log2  <= cfg.data;
				CFG_CLOCK:    cfg_q.has_clock      <= cfg.data[0];
				default:      cfg_q                <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1   <= req.req_type;
			address_s1    <= req.address;
			write_data_s1 <= req.write_data;
		end
	end

	cbc_ctrl #(
		.RAM_BYTES     (RAM_BYTES),
		.ROM_ADDR_BITS (ROM_ADDR_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (s1_fire),
		.req_type    (req_type_s1),
		.address     (address_s1),
		.write_data  (write_data_s1),
		.cfg         (cfg_q),
		.rtc_live    (rtc_live),
		.rtc_latched (rtc_latched),
		.ram_ctl     (dec_ram_ctl),
		.ram_addr    (dec_ram_addr),
		.ram_wdata   (dec_ram_wdata),
		.rtc_cmd     (rtc_cmd),
		.res         (dec_res)
	);

	cbc_rtc u_rtc (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rtc_cmd),
		.live    (rtc_live),
		.latched (rtc_latched)
	);

	// clearing pass after reset, one byte a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(RAM_BYTES - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// s1 is empty during the clearing pass, so the port is free for it
	assign ram_en    = clr_done_q ? dec_ram_ctl.en : 1'b1;
	assign ram_we    = clr_done_q ? dec_ram_ctl.we : 1'b1;
	assign ram_addr  = clr_done_q ? dec_ram_addr : clr_idx_q;
	assign ram_wdata = clr_done_q ? dec_ram_wdata : OPEN_BUS;

	cbc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_BYTES)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// result register; the ram read data lands alongside it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fetch_s2       <= dec_res.fetch;
			rom_address_s2 <= dec_res.rom_address;
			data_s2        <= dec_res.data;
			src_s2         <= dec_res.src;
			dirty_s2       <= dec_res.dirty;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.rom_fetch   = fetch_s2;
	assign rsp.rom_address = rom_address_s2;
	assign rsp.ram_dirty   = dirty_s2;

	// nibble ram reads float high in the upper half
	always_comb begin
		case (src_s2)
			SRC_RAM_BYTE:   rsp.read_data = ram_rdata;
			SRC_RAM_NIBBLE: rsp.read_data = {4'hF, ram_rdata[3:0]};
			default:        rsp.read_data = data_s2;
		endcase
	end

`ifndef ASSERT_OFF
	// nothing enters the pipe while the ram is being cleared
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done_q |-> !valid_s1)
		else $error("request staged during ram clearing pass");

	// a decoded beat always reaches the result register
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> valid_s2)
		else $error("decoded beat lost before the result stage");

	// a rom fetch never carries ram or clock data
	a_fetch_open_bus: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.rom_fetch |-> rsp.read_data == OPEN_BUS)
		else $error("rom fetch with non open-bus read data");

	// the dirty flag never drops once reported
	a_dirty_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.ram_dirty |=> !rsp.valid || rsp.ram_dirty)
		else $error("dirty flag cleared after being set");
`endif

endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for the cartridge bank controller: bus reads, writes and clock ticks
module tb_top import cbc_pkg::*; ();

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 9;
	localparam int LIMIT_CYCLES   = 400000;
	localparam int IDLE_PCT       = 17;
	localparam int SQUEEZE_CYCLES = 150;
	localparam int SET_ITEMS      = 102;
	localparam int REPORT_MAX     = 10;
	localparam int DRAIN_CYCLES   = 8;
	localparam int N_SETUPS       = 11;
	localparam int SQUEEZE_SET    = 2;
	localparam int CALM_SET       = 5;
	localparam int SCRIPT_PCT     = 6;
	localparam int ROM_LG_MAX     = ROM_ADDR_BITS_DEF - 14;
	localparam int RAM_BANK_BYTES = 8192;

	// codes the package has no name for
	localparam logic [1:0]        REQ_UNKNOWN = 2'd3;
	localparam logic [2:0]        MAP_ODD_LO  = 3'd5;
	localparam logic [2:0]        MAP_ODD_HI  = 3'd7;
	localparam logic [DATA_W-1:0] LATCH_ARM   = 8'h00;
	localparam logic [DATA_W-1:0] LATCH_FIRE  = 8'h01;
	localparam logic [DATA_W-1:0] DH_KEEP     = 8'hC1;
	localparam logic [DATA_W-1:0] DH_HALT     = 8'h40;
	localparam logic [DATA_W-1:0] RTC_BANK_X  = 8'h0D;

	// bus map
	localparam logic [ADDR_W-1:0] ROM_HI_BASE = 16'h4000;
	localparam logic [ADDR_W-1:0] ROM_TOP     = 16'h8000;
	localparam logic [ADDR_W-1:0] WIN_LO      = 16'hA000;
	localparam logic [ADDR_W-1:0] WIN_HI      = 16'hC000;
	localparam logic [ADDR_W-1:0] BANK_SEL    = 16'h4000;
	localparam logic [ADDR_W-1:0] LATCH_REG   = 16'h6000;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} bus_access_t;

	typedef struct packed {
		logic                  fetch;
		logic [ROM_ADDR_W-1:0] rom_addr;
		logic [DATA_W-1:0]     rdata;
		logic                  dirty;
	} cart_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	cbc_req_if bus_req ();
	cbc_rsp_if bus_rsp ();
	cbc_cfg_if cfg_wr ();

	cartridge_bank_controller_rtc_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (bus_req),
		.rsp   (bus_rsp),
		.cfg   (cfg_wr)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------- mapper model
	// own copy of the configuration and of everything the cartridge remembers
	cfg_t              cart_cfg;
	logic              ram_on;
	logic [8:0]        rom_bank;
	logic [7:0]        ram_bank;
	logic              bank_mode;
	rtc_t              rtc_run;
	rtc_t              rtc_snap;
	logic [7:0]        latch_last;
	logic              dirty;
	logic [DATA_W-1:0] cart_mem [0:RAM_BYTES_DEF-1];

	function automatic void model_reset();
		cart_cfg   = '{mapper_type: MAP_NONE, rom_banks_log2: 4'd1, ram_size_log2: 5'd0,
			has_clock: 1'b0};
		ram_on     = 1'b0;
		rom_bank   = 9'd1;
		ram_bank   = '0;
		bank_mode  = 1'b0;
		rtc_run    = '0;
		rtc_snap   = '0;
		latch_last = 8'hFF;
		dirty      = 1'b0;
		foreach (cart_mem[i]) cart_mem[i] = OPEN_BUS;
	endfunction

	// codes above the known mappers fall back to a plain cartridge
	function automatic mapper_t live_mapper();
		return (cart_cfg.mapper_type > MAP_MBC5) ? MAP_NONE : mapper_t'(cart_cfg.mapper_type);
	endfunction

	// bank number masked to the rom size, which saturates at the address width
	function automatic logic [ROM_ADDR_W-1:0] rom_byte_addr(input int unsigned bank,
		input logic [ADDR_W-1:0] a);
		int unsigned lg;
		lg   = (cart_cfg.rom_banks_log2 > ROM_LG_MAX) ? ROM_LG_MAX : cart_cfg.rom_banks_log2;
		bank = bank & ((32'd1 << lg) - 32'd1);
		return ROM_ADDR_W'((bank << 14) | a[13:0]);
	endfunction

	function automatic int unsigned ram_bytes();
		int unsigned sz;
		if (cart_cfg.ram_size_log2 == 0) return 0;
		if (cart_cfg.ram_size_log2 >= 20) return RAM_BYTES_DEF;
		sz = 32'd1 << cart_cfg.ram_size_log2;
		return (sz < RAM_BYTES_DEF) ? sz : RAM_BYTES_DEF;
	endfunction

	// offsets wrap modulo the usable size, small rams have a single bank
	function automatic int unsigned ram_slot(input logic [ADDR_W-1:0] a, input int unsigned sz);
		int unsigned bank;
		int unsigned banks;
		banks = sz / RAM_BANK_BYTES;
		case (live_mapper())
			MAP_MBC1: bank = bank_mode ? ram_bank[1:0] : 0;
			MAP_MBC3: bank = ram_bank[2:0];
			MAP_MBC5: bank = ram_bank[3:0];
			default:  bank = 0;
		endcase
		bank = (banks > 0) ? bank % banks : 0;
		return (bank * RAM_BANK_BYTES + a[12:0]) % sz;
	endfunction

	function automatic logic [DATA_W-1:0] window_read(input logic [ADDR_W-1:0] a);
		mapper_t     k;
		int unsigned sz;
		k  = live_mapper();
		sz = ram_bytes();
		if (k != MAP_NONE && !ram_on) return OPEN_BUS;
		// nibble ram ignores the configured size
		if (k == MAP_MBC2) return {4'hF, cart_mem[a[8:0]][3:0]};
		// clock banks read the latched copy, whether or not a clock is fitted
		if (k == MAP_MBC3 && ram_bank >= RTC_BANK_LO) begin
			case (ram_bank)
				RTC_BANK_SEC: return {2'b00, rtc_snap.sec};
				RTC_BANK_MIN: return {2'b00, rtc_snap.min};
				RTC_BANK_HRS: return {3'b000, rtc_snap.hrs};
				RTC_BANK_DL:  return rtc_snap.dl;
				RTC_BANK_DH:  return rtc_snap.dh;
				default:      return OPEN_BUS;
			endcase
		end
		if (sz == 0) return OPEN_BUS;
		return cart_mem[ram_slot(a, sz)];
	endfunction

	function automatic void window_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		mapper_t     k;
		int unsigned sz;
		k  = live_mapper();
		sz = ram_bytes();
		if (k != MAP_NONE && !ram_on) return;
		if (k == MAP_MBC2) begin
			cart_mem[a[8:0]] = {4'h0, d[3:0]};
			dirty = 1'b1;
			return;
		end
		// clock writes hit the live counters; banks past the clock only mark dirty
		if (k == MAP_MBC3 && ram_bank >= RTC_BANK_LO) begin
			case (ram_bank)
				RTC_BANK_SEC: rtc_run.sec = d[5:0];
				RTC_BANK_MIN: rtc_run.min = d[5:0];
				RTC_BANK_HRS: rtc_run.hrs = d[4:0];
				RTC_BANK_DL:  rtc_run.dl  = d;
				RTC_BANK_DH:  rtc_run.dh  = d & DH_KEEP;
				default: ;
			endcase
			dirty = 1'b1;
			return;
		end
		// no ram: the write vanishes and leaves dirty alone
		if (sz == 0) return;
		cart_mem[ram_slot(a, sz)] = d;
		dirty = 1'b1;
	endfunction

	function automatic void reg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		case (live_mapper())
			MAP_MBC1: begin
				if (a < 16'h2000) ram_on = (d[3:0] == RAM_EN_KEY);
				else if (a < 16'h4000) rom_bank = (d[4:0] == 0) ? 9'd1 : {4'd0, d[4:0]};
				else if (a < 16'h6000) ram_bank = {6'd0, d[1:0]};
				else bank_mode = d[0];
			end
			MAP_MBC2: begin
				// address bit 8 picks rom bank or ram enable
				if (a < 16'h4000) begin
					if (a[8]) rom_bank = (d[3:0] == 0) ? 9'd1 : {5'd0, d[3:0]};
					else ram_on = (d[3:0] == RAM_EN_KEY);
				end
			end
			MAP_MBC3: begin
				if (a < 16'h2000) ram_on = (d[3:0] == RAM_EN_KEY);
				else if (a < 16'h4000) rom_bank = (d[6:0] == 0) ? 9'd1 : {2'd0, d[6:0]};
				else if (a < 16'h6000) ram_bank = d;
				else begin
					// latch on a zero followed by a one
					if (latch_last == LATCH_ARM && d == LATCH_FIRE) rtc_snap = rtc_run;
					latch_last = d;
				end
			end
			MAP_MBC5: begin
				if (a < 16'h2000) ram_on = (d[3:0] == RAM_EN_KEY);
				else if (a < 16'h3000) rom_bank = {rom_bank[8], d};
				else if (a < 16'h4000) rom_bank = {d[0], rom_bank[7:0]};
				else if (a < 16'h6000) ram_bank = {4'd0, d[3:0]};
			end
			default: ;
		endcase
	endfunction

	// out-of-range fields just count on under their masks, carry only on exact limits
	function automatic void clock_advance();
		logic [9:0] day;
		if (!cart_cfg.has_clock || rtc_run.dh[6]) return;
		dirty = 1'b1;
		rtc_run.sec = rtc_run.sec + 6'd1;
		if (rtc_run.sec != 6'd60) return;
		rtc_run.sec = '0;
		rtc_run.min = rtc_run.min + 6'd1;
		if (rtc_run.min != 6'd60) return;
		rtc_run.min = '0;
		rtc_run.hrs = rtc_run.hrs + 5'd1;
		if (rtc_run.hrs != 5'd24) return;
		rtc_run.hrs = '0;
		day = {1'b0, rtc_run.dh[0], rtc_run.dl} + 10'd1;
		// day counter wraps and leaves the sticky carry set
		if (day >= 10'd512) begin
			day           = '0;
			rtc_run.dh[7] = 1'b1;
		end
		rtc_run.dl    = day[7:0];
		rtc_run.dh[0] = day[8];
	endfunction

	function automatic cart_reply_t predict_access(input bus_access_t it);
		cart_reply_t r;
		int unsigned bank;
		mapper_t     k;
		k          = live_mapper();
		r.fetch    = 1'b0;
		r.rom_addr = '0;
		r.rdata    = OPEN_BUS;
		case (it.op)
			REQ_READ: begin
				if (it.addr < ROM_HI_BASE) begin
					// fixed window, remapped only in the second banking mode
					bank       = (k == MAP_MBC1 && bank_mode) ? {ram_bank[1:0], 5'd0} : 0;
					r.fetch    = 1'b1;
					r.rom_addr = rom_byte_addr(bank, it.addr);
				end else if (it.addr < ROM_TOP) begin
					case (k)
						MAP_MBC1: bank = {ram_bank[1:0], rom_bank[4:0]};
						MAP_MBC2: bank = rom_bank[3:0];
						MAP_MBC3: bank = rom_bank[6:0];
						MAP_MBC5: bank = rom_bank;
						default:  bank = 1;
					endcase
					r.fetch    = 1'b1;
					r.rom_addr = rom_byte_addr(bank, it.addr);
				end else if (it.addr >= WIN_LO && it.addr < WIN_HI) begin
					r.rdata = window_read(it.addr);
				end
			end
			REQ_WRITE: begin
				if (it.addr < ROM_TOP) reg_write(it.addr, it.data);
				else if (it.addr >= WIN_LO && it.addr < WIN_HI) window_write(it.addr, it.data);
			end
			REQ_TICK: clock_advance();
			default: ;
		endcase
		r.dirty = dirty;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus store
	bus_access_t access_backlog [$];
	cart_reply_t replies_due [$];
	bus_access_t on_bus;
	int          queued;
	int          accepted;
	int          replies_seen;
	int          faults;
	int          setups_run;
	int          squeeze_asks;
	int          cycles;
	logic        calm;

	function automatic void offer(input logic [1:0] op, input logic [ADDR_W-1:0] a,
		input logic [DATA_W-1:0] d);
		bus_access_t entry;
		entry          = '{op: op, addr: a, data: d};
		access_backlog = {access_backlog, entry};
		queued++;
	endfunction

	// select a clock register and write it through the ram window
	function automatic void rtc_poke(input logic [DATA_W-1:0] sel, input logic [DATA_W-1:0] v);
		offer(REQ_WRITE, BANK_SEL | 16'($urandom_range(16'h1FFF)), sel);
		offer(REQ_WRITE, WIN_LO | 16'($urandom_range(16'h1FFF)), v);
	endfunction

	// clock set near its carries, a few ticks, latch, then read every register back
	function automatic void clock_script();
		logic [DATA_W-1:0] sel;
		logic [DATA_W-1:0] v;
		offer(REQ_WRITE, 16'($urandom_range(16'h1FFF)), {4'($urandom), RAM_EN_KEY});
		for (int f = 0; f < 5; f++) begin
			sel = RTC_BANK_SEC + 8'(f);
			case (sel)
				RTC_BANK_SEC: v = 8'($urandom_range(56, 63));
				RTC_BANK_MIN: v = 8'($urandom_range(57, 63));
				RTC_BANK_HRS: v = 8'($urandom_range(21, 31));
				RTC_BANK_DL:  v = 8'($urandom_range(248, 255));
				default:      v = {1'($urandom), 1'($urandom_range(9) == 0), 5'($urandom),
					1'($urandom)};
			endcase
			rtc_poke(sel, v);
		end
		repeat ($urandom_range(1, 8)) offer(REQ_TICK, 16'($urandom), 8'($urandom));
		offer(REQ_WRITE, LATCH_REG | 16'($urandom_range(16'h1FFF)), LATCH_ARM);
		offer(REQ_WRITE, LATCH_REG | 16'($urandom_range(16'h1FFF)), LATCH_FIRE);
		for (int f = 0; f < 5; f++) begin
			offer(REQ_WRITE, BANK_SEL | 16'($urandom_range(16'h1FFF)), RTC_BANK_SEC + 8'(f));
			offer(REQ_READ, WIN_LO | 16'($urandom_range(16'h1FFF)), 8'($urandom));
		end
	endfunction

	// mostly register and window traffic with data biased to the useful codes
	function automatic void offer_random();
		int unsigned       pick;
		logic [DATA_W-1:0] d;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0:       d = {4'($urandom), RAM_EN_KEY};
			1:       d = 8'($urandom_range(15));
			2:       d = 8'($urandom_range(1));
			default: d = 8'($urandom);
		endcase
		if (pick < 10)
			offer(2'($urandom), 16'($urandom), 8'($urandom));
		else if (pick < 25)
			offer(REQ_READ, 16'($urandom_range(16'h7FFF)), d);
		else if (pick < 40)
			offer(REQ_WRITE, 16'($urandom_range(16'h7FFF)), d);
		else if (pick < 75)
			offer($urandom_range(1) ? REQ_WRITE : REQ_READ,
				WIN_LO | 16'($urandom_range(16'h1FFF)), 8'($urandom));
		else if (pick < 88)
			offer(REQ_TICK, 16'($urandom), 8'($urandom));
		else
			offer($urandom_range(1) ? REQ_WRITE : REQ_READ,
				$urandom_range(1) ? (ROM_TOP | 16'($urandom_range(16'h1FFF)))
					: 16'($urandom_range(16'hC000, 16'hFFFF)), 8'($urandom));
	endfunction

	// ---------------------------------------------------------------- configuration port
	task automatic program_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_wr.valid <= 1'b1;
		cfg_wr.index <= idx;
		cfg_wr.data  <= v;
		@(posedge clk);
		while (!cfg_wr.ready) @(posedge clk);
		case (idx)
			CFG_MAPPER:   cart_cfg.mapper_type    = v[2:0];
			CFG_ROM_LOG2: cart_cfg.rom_banks_log2 = v[3:0];
			CFG_RAM_LOG2: cart_cfg.ram_size_log2  = v[4:0];
			CFG_CLOCK:    cart_cfg.has_clock      = v[0];
			default: ;
		endcase
	endtask

	// valid stays high across the four beats and drops after the last
	task automatic apply_setup(input cfg_t s);
		program_reg(CFG_MAPPER, 5'(s.mapper_type));
		program_reg(CFG_ROM_LOG2, 5'(s.rom_banks_log2));
		program_reg(CFG_RAM_LOG2, s.ram_size_log2);
		program_reg(CFG_CLOCK, 5'(s.has_clock));
		cfg_wr.valid <= 1'b0;
		setups_run++;
	endtask

	// everything sent has been answered, then a few quiet cycles
	task automatic settle();
		while (queued != accepted || replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- request driver
	// holds a beat until taken, then loads the next one or idles at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (bus_req.valid && bus_req.ready) begin
				replies_due = {replies_due, predict_access(on_bus)};
				accepted++;
			end
			if (!bus_req.valid || bus_req.ready) begin
				if (access_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					on_bus = access_backlog.pop_front();
					bus_req.valid      <= 1'b1;
					bus_req.req_type   <= on_bus.op;
					bus_req.address    <= on_bus.addr;
					bus_req.write_data <= on_bus.data;
				end else begin
					bus_req.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- result monitor
	// random back-pressure, plus a long hold-off whenever one is asked for
	always @(posedge clk) begin : watch
		cart_reply_t got;
		cart_reply_t want;
		int          hold_left;
		int          squeeze_seen;
		if (arst_n) begin
			if (bus_rsp.valid && bus_rsp.ready) begin
				got = '{fetch: bus_rsp.rom_fetch, rom_addr: bus_rsp.rom_address,
					rdata: bus_rsp.read_data, dirty: bus_rsp.ram_dirty};
				replies_seen++;
				if (replies_due.size() == 0) begin
					faults++;
					if (faults <= REPORT_MAX)
						$display("unexpected result beat: fetch %0b rom %06h data %02h dirty %0b",
							got.fetch, got.rom_addr, got.rdata, got.dirty);
				end else begin
					want = replies_due.pop_front();
					if (got != want) begin
						faults++;
						if (faults <= REPORT_MAX)
							$display("result %0d mismatch: expected %0b %06h %02h %0b, actual %0b %06h %02h %0b",
								replies_seen, want.fetch, want.rom_addr, want.rdata, want.dirty,
								got.fetch, got.rom_addr, got.rdata, got.dirty);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				bus_rsp.ready <= 1'b0;
			end else if (squeeze_seen != squeeze_asks) begin
				squeeze_seen++;
				hold_left = SQUEEZE_CYCLES;
				bus_rsp.ready <= 1'b0;
			end else begin
				bus_rsp.ready <= calm || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	// generous: covers the ram clearing pass after reset as well
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				replies_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequencing
	initial begin
		cfg_t setups [0:N_SETUPS-1];
		int   target;
		arst_n             = 1'b0;
		bus_req.valid      = 1'b0;
		bus_req.req_type   = REQ_READ;
		bus_req.address    = '0;
		bus_req.write_data = '0;
		bus_rsp.ready      = 1'b0;
		cfg_wr.valid       = 1'b0;
		cfg_wr.index       = CFG_MAPPER;
		cfg_wr.data        = '0;
		calm               = 1'b0;
		model_reset();
		// extremes of every register: odd mapper codes, saturating rom, oversized ram
		setups = '{
			'{MAP_NONE,   4'd0,  5'd13, 1'b0},
			'{MAP_MBC1,   4'd7,  5'd15, 1'b0},
			'{MAP_MBC1,   4'd5,  5'd9,  1'b1},
			'{MAP_MBC2,   4'd4,  5'd0,  1'b0},
			'{MAP_MBC3,   4'd7,  5'd15, 1'b1},
			'{MAP_MBC3,   4'd2,  5'd0,  1'b0},
			'{MAP_MBC5,   4'd9,  5'd17, 1'b0},
			'{MAP_MBC5,   4'd15, 5'd31, 1'b1},
			'{MAP_ODD_HI, 4'd1,  5'd1,  1'b1},
			'{MAP_ODD_LO, 4'd12, 5'd20, 1'b0},
			'{MAP_MBC3,   4'd1,  5'd14, 1'b1}
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clock-equipped cartridge, walked through its corner cases
		apply_setup('{MAP_MBC3, 4'd9, 5'd15, 1'b1});
		offer(REQ_READ, 16'h0000, 8'h00);
		offer(REQ_READ, 16'h7FFF, 8'hFF);
		offer(REQ_UNKNOWN, 16'hFFFF, 8'hFF);
		offer(REQ_WRITE, 16'h0000, {4'h0, RAM_EN_KEY});
		offer(REQ_WRITE, 16'h2000, 8'h00);              // bank zero reads as bank one
		// clock one second before the day counter wraps
		rtc_poke(RTC_BANK_DH, 8'h01);
		rtc_poke(RTC_BANK_DL, 8'hFF);
		rtc_poke(RTC_BANK_HRS, 8'd23);
		rtc_poke(RTC_BANK_MIN, 8'd59);
		rtc_poke(RTC_BANK_SEC, 8'd59);
		offer(REQ_TICK, 16'h0000, 8'h00);
		offer(REQ_WRITE, BANK_SEL, RTC_BANK_DH);
		offer(REQ_WRITE, LATCH_REG, LATCH_ARM);
		offer(REQ_WRITE, LATCH_REG, LATCH_FIRE);
		offer(REQ_READ, WIN_LO, 8'h00);                 // sticky carry visible
		offer(REQ_WRITE, WIN_LO, DH_HALT);              // halt bit set
		offer(REQ_TICK, 16'hFFFF, 8'hFF);               // halted, nothing moves
		offer(REQ_WRITE, BANK_SEL, RTC_BANK_X);
		offer(REQ_READ, 16'hBFFF, 8'h00);               // past the clock registers
		offer(REQ_WRITE, BANK_SEL, 8'h00);
		offer(REQ_READ, 16'hBFFF, 8'h00);
		offer(REQ_READ, ROM_TOP, 8'h00);                // unmapped
		settle();

		// random sets, each behind a fresh configuration
		for (int p = 0; p < N_SETUPS; p++) begin
			apply_setup(setups[p]);
			calm = (p == CALM_SET);
			if (p == SQUEEZE_SET) squeeze_asks++;
			target = queued + SET_ITEMS;
			while (queued < target) begin
				if (live_mapper() == MAP_MBC3 && $urandom_range(99) < SCRIPT_PCT) clock_script();
				else offer_random();
			end
			// the sender waits for every result before the next setup
			settle();
		end
		calm = 1'b0;

		$display("ran %0d bus beats (reads, writes, ticks, unknown codes) over %0d setups",
			accepted, setups_run);
		$display("%0d result beats checked, %0d mismatching", replies_seen, faults);
		if (faults == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- cartridge_bank_controller_rtc_unit.f -----
rtl/cbc_pkg.sv
rtl/cbc_req_if.sv
rtl/cbc_rsp_if.sv
rtl/cbc_cfg_if.sv
rtl/cbc_ram.sv
rtl/cbc_rtc.sv
rtl/cbc_ctrl.sv
rtl/cartridge_bank_controller_rtc_unit.sv
tb/tb_top.sv
